>>> rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is high
`define RPN_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked check that also holds during reset
`define RPN_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// types, command codes, status codes and helpers for the rpn evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

   // input and result beats
   typedef struct packed {
      logic [7:0] character;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic signed [63:0] value;
      logic [2:0]         status;
   } rsp_type;

   // command kinds passed from the front to the back
   localparam logic [2:0] CMD_PUSH = 3'd0;
   localparam logic [2:0] CMD_ADD  = 3'd1;
   localparam logic [2:0] CMD_SUB  = 3'd2;
   localparam logic [2:0] CMD_MUL  = 3'd3;
   localparam logic [2:0] CMD_DIV  = 3'd4;
   localparam logic [2:0] CMD_NEG  = 3'd5;
   localparam logic [2:0] CMD_ERR  = 3'd6;
   localparam logic [2:0] CMD_END  = 3'd7;

   typedef struct packed {
      logic [2:0]  kind;
      logic [2:0]  code;
      logic [63:0] data;
   } cmd_type;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_NUM   = 3'd1;
   localparam logic [2:0] ST_BAD_OP    = 3'd2;
   localparam logic [2:0] ST_FEW_OPS   = 3'd3;
   localparam logic [2:0] ST_DIV_ZERO  = 3'd4;
   localparam logic [2:0] ST_INVALID   = 3'd5;
   localparam logic [2:0] ST_OVERFLOW  = 3'd6;

   // characters
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam int          MAX_FRAC_DIGITS = 18;
   localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;
   localparam logic [63:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

   // powers of ten for the fraction denominator
   function automatic logic [59:0] pow10(input logic [4:0] n);
      logic [59:0] p;
      case (n)
         5'd0:    p = 60'd1;
         5'd1:    p = 60'd10;
         5'd2:    p = 60'd100;
         5'd3:    p = 60'd1000;
         5'd4:    p = 60'd10000;
         5'd5:    p = 60'd100000;
         5'd6:    p = 60'd1000000;
         5'd7:    p = 60'd10000000;
         5'd8:    p = 60'd100000000;
         5'd9:    p = 60'd1000000000;
         5'd10:   p = 60'd10000000000;
         5'd11:   p = 60'd100000000000;
         5'd12:   p = 60'd1000000000000;
         5'd13:   p = 60'd10000000000000;
         5'd14:   p = 60'd100000000000000;
         5'd15:   p = 60'd1000000000000000;
         5'd16:   p = 60'd10000000000000000;
         5'd17:   p = 60'd100000000000000000;
         default: p = 60'd1000000000000000000;
      endcase
      return p;
   endfunction

   // signed result from sign and magnitude, saturated
   function automatic logic [63:0] sat_mag(input logic neg, input logic hi_nz,
                                           input logic [63:0] lo);
      logic [63:0] r;
      if (neg) begin
         r = (hi_nz || lo > VAL_MIN) ? VAL_MIN : (64'd0 - lo);
      end else begin
         r = (hi_nz || lo[63]) ? VAL_MAX : lo;
      end
      return r;
   endfunction

   function automatic logic [63:0] mag_of(input logic [63:0] v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

endpackage

`default_nettype wire

>>> rtl/rpn_stack_evaluator.sv
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// evaluates a space separated rpn string in signed fixed point
// ----------------------------------------------------------------------------
// channel   dir  beat
// req_      in   one character or the end marker
// rsp_      out  value and status, one per end marker
//
// closing a number runs the fraction scaling loop, during which the parser
// stalls its input.
// the stack engine reads the second operand from the ram for add or subtract,
// and runs a partial product sequence to multiply and a bit loop to divide.
// a four entry command queue lets the parser run ahead of the engine.
// reset is synchronous; the stack needs no clearing.
// a stalled result holds in the output register while parsing continues.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_stack_evaluator #(
   parameter int STACK_DEPTH   = 64,
   parameter int TOKEN_CHARS   = 32,
   parameter int FRACTION_BITS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire rpn_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rpn_pkg::rsp_type      rsp_data
);

   logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
   rpn_pkg::cmd_type cmd_data, cmd_head;

   // parser
   rpn_front #(.TOKEN_CHARS(TOKEN_CHARS), .FRACTION_BITS(FRACTION_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd_data (cmd_data),
      .cmd_full (cmd_full)
   );

   // command queue
   rpn_cmd_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .push_cmd(cmd_data),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .empty   (cmd_empty),
      .head    (cmd_head)
   );

   // stack engine
   rpn_back #(.STACK_DEPTH(STACK_DEPTH), .FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_empty(cmd_empty),
      .cmd_head (cmd_head),
      .cmd_pop  (cmd_pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

>>> rtl/rpn_ram.sv
// ----------------------------------------------------------------------------
// rpn_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/rpn_cmd_fifo.sv
// ----------------------------------------------------------------------------
// rpn_cmd_fifo
// short command queue between the parser and the stack engine
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_cmd_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire rpn_pkg::cmd_type push_cmd,
   output logic                  full,
   input  wire logic             pop,
   output logic                  empty,
   output rpn_pkg::cmd_type      head
);

   localparam int DEPTH = 4;

   rpn_pkg::cmd_type store_ff [DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;

   assign full  = (count_ff == 3'(DEPTH));
   assign empty = (count_ff == 3'd0);
   assign head  = store_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + (push ? 2'd1 : 2'd0);
      rd_ptr_in = rd_ptr_ff + (pop ? 2'd1 : 2'd0);
      count_in  = count_ff + (push ? 3'd1 : 3'd0) - (pop ? 3'd1 : 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

>>> rtl/rpn_front.sv
// ----------------------------------------------------------------------------
// rpn_front
// character parser: builds numbers, converts fractions, issues commands
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_front #(
   parameter int TOKEN_CHARS   = 32,
   parameter int FRACTION_BITS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire rpn_pkg::req_type req_data,
   output logic                  cmd_push,
   output rpn_pkg::cmd_type      cmd_data,
   input  wire logic             cmd_full
);

   localparam int IW  = 64 - FRACTION_BITS;
   localparam int TLW = $clog2(TOKEN_CHARS + 1);
   localparam int SW  = $clog2(FRACTION_BITS + 1);
   localparam logic F_IDLE = 1'b0;
   localparam logic F_CONV = 1'b1;

   logic            state_ff, state_in;
   logic [IW-1:0]   int_ff, int_in;
   logic [59:0]     frac_ff, frac_in;
   logic [4:0]      fdig_ff, fdig_in;
   logic [TLW-1:0]  len_ff, len_in;
   logic [1:0]      dot_ff, dot_in;
   logic [60:0]     rem_ff, rem_in;
   logic [59:0]     den_ff, den_in;
   logic [FRACTION_BITS-1:0] q_ff, q_in;
   logic [SW-1:0]   step_ff, step_in;

   logic            accept;
   logic [7:0]      ch;
   logic [3:0]      digit;
   logic [IW+3:0]   int_next;
   logic [60:0]     rem_sh;
   logic            bad_num;

   assign ch       = req_data.character;
   assign digit    = 4'(ch - rpn_pkg::CH_ZERO);
   assign req_stall = (state_ff != F_IDLE) || cmd_full;
   assign accept   = req_valid && !req_stall;
   assign int_next = ({4'd0, int_ff} << 3) + ({4'd0, int_ff} << 1) + (IW+4)'(digit);
   assign rem_sh   = {rem_ff[59:0], 1'b0};
   assign bad_num  = (len_ff >= TLW'(TOKEN_CHARS)) || (dot_ff > 2'd1)
                     || (len_ff <= TLW'(dot_ff));

   always_comb begin
      state_in = state_ff;
      int_in   = int_ff;
      frac_in  = frac_ff;
      fdig_in  = fdig_ff;
      len_in   = len_ff;
      dot_in   = dot_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      q_in     = q_ff;
      step_in  = step_ff;
      cmd_push = 1'b0;
      cmd_data = '{kind: rpn_pkg::CMD_ERR, code: rpn_pkg::ST_OK, data: 64'd0};

      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               if (req_data.end_of_text) begin
                  // terminator: drop open token
                  cmd_push      = 1'b1;
                  cmd_data.kind = rpn_pkg::CMD_END;
                  int_in = '0; frac_in = '0; fdig_in = '0; len_in = '0; dot_in = '0;
               end else if (ch == rpn_pkg::CH_SPACE) begin
                  if (len_ff != '0) begin
                     if (bad_num) begin
                        cmd_push      = 1'b1;
                        cmd_data.code = rpn_pkg::ST_BAD_NUM;
                     end else if (int_ff[IW-1]) begin
                        cmd_push      = 1'b1;
                        cmd_data.kind = rpn_pkg::CMD_PUSH;
                        cmd_data.data = rpn_pkg::VAL_MAX;
                     end else begin
                        // start fraction scaling
                        state_in = F_CONV;
                        rem_in   = {1'b0, frac_ff};
                        den_in   = rpn_pkg::pow10(fdig_ff);
                        q_in     = '0;
                        step_in  = '0;
                     end
                     if (!(state_in == F_CONV)) begin
                        int_in = '0; frac_in = '0; fdig_in = '0;
                        len_in = '0; dot_in = '0;
                     end
                  end
               end else if (ch >= rpn_pkg::CH_ZERO && ch <= rpn_pkg::CH_NINE) begin
                  if (dot_ff == 2'd0) begin
                     if (!int_ff[IW-1]) begin
                        int_in = (int_next > (IW+4)'({1'b1, {(IW-1){1'b0}}}))
                                 ? {1'b1, {(IW-1){1'b0}}} : int_next[IW-1:0];
                     end
                  end else if (fdig_ff < 5'(rpn_pkg::MAX_FRAC_DIGITS)) begin
                     frac_in = (frac_ff << 3) + (frac_ff << 1) + 60'(digit);
                     fdig_in = fdig_ff + 5'd1;
                  end
                  if (len_ff < TLW'(TOKEN_CHARS)) len_in = len_ff + TLW'(1);
               end else if (ch == rpn_pkg::CH_DOT) begin
                  if (dot_ff < 2'd2) dot_in = dot_ff + 2'd1;
                  if (len_ff < TLW'(TOKEN_CHARS)) len_in = len_ff + TLW'(1);
               end else begin
                  cmd_push = 1'b1;
                  unique case (ch)
                     rpn_pkg::CH_PLUS:  cmd_data.kind = rpn_pkg::CMD_ADD;
                     rpn_pkg::CH_MINUS: cmd_data.kind = rpn_pkg::CMD_SUB;
                     rpn_pkg::CH_STAR:  cmd_data.kind = rpn_pkg::CMD_MUL;
                     rpn_pkg::CH_SLASH: cmd_data.kind = rpn_pkg::CMD_DIV;
                     rpn_pkg::CH_TILDE: cmd_data.kind = rpn_pkg::CMD_NEG;
                     default:           cmd_data.code = rpn_pkg::ST_BAD_OP;
                  endcase
               end
            end
         end
         F_CONV: begin
            // one quotient bit a cycle
            if (step_ff != SW'(FRACTION_BITS)) begin
               if (rem_sh >= {1'b0, den_ff}) begin
                  rem_in = rem_sh - {1'b0, den_ff};
                  q_in   = {q_ff[FRACTION_BITS-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh;
                  q_in   = {q_ff[FRACTION_BITS-2:0], 1'b0};
               end
               step_in = step_ff + SW'(1);
            end else if (!cmd_full) begin
               cmd_push      = 1'b1;
               cmd_data.kind = rpn_pkg::CMD_PUSH;
               cmd_data.data = {1'b0, int_ff[IW-2:0], q_ff};
               state_in = F_IDLE;
               int_in = '0; frac_in = '0; fdig_in = '0; len_in = '0; dot_in = '0;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         int_ff   <= '0;
         frac_ff  <= '0;
         fdig_ff  <= '0;
         len_ff   <= '0;
         dot_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         int_ff   <= int_in;
         frac_ff  <= frac_in;
         fdig_ff  <= fdig_in;
         len_ff   <= len_in;
         dot_ff   <= dot_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

endmodule

`default_nettype wire

>>> rtl/rpn_back.sv
// ----------------------------------------------------------------------------
// rpn_back
// stack engine: value stack in ram, cached top, iterative multiply and divide
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_back #(
   parameter int STACK_DEPTH   = 64,
   parameter int FRACTION_BITS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_empty,
   input  wire rpn_pkg::cmd_type cmd_head,
   output logic                  cmd_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rpn_pkg::rsp_type      rsp_data
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [2:0] B_IDLE = 3'd0;
   localparam logic [2:0] B_READ = 3'd1;
   localparam logic [2:0] B_MUL  = 3'd2;
   localparam logic [2:0] B_DIV  = 3'd3;
   localparam logic [2:0] B_DONE = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [2:0]    err_ff, err_in;
   logic [63:0]   tos_ff, tos_in;
   logic [2:0]    op_ff, op_in;
   logic          neg_ff, neg_in;
   logic [63:0]   ua_ff, ua_in;
   logic [63:0]   ub_ff, ub_in;
   logic [31:0]   prod_a, prod_b;
   logic [63:0]   prod_ff, prod_in;
   logic [1:0]    sh_ff, sh_in;
   logic [127:0]  acc_ff, acc_in;
   logic [7:0]    step_ff, step_in;
   logic [127:0]  num_ff, num_in;
   logic [64:0]   rem_ff, rem_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rpn_pkg::rsp_type rsp_ff, rsp_in;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [63:0]   rd_data;
   logic [CW-1:0] cnt_m1, cnt_m2;
   logic          out_free;
   logic [63:0]   x, sum, dif;
   logic [64:0]   rem_sh;
   logic [127:0]  prod_sh;

   rpn_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_stack (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(tos_ff),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign cnt_m1   = count_ff - CW'(1);
   assign cnt_m2   = count_ff - CW'(2);
   assign wr_addr  = cnt_m1[AW-1:0];
   assign rd_addr  = cnt_m2[AW-1:0];
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // saturating add and subtract of second (x) and top
   assign x   = rd_data;
   assign sum = x + tos_ff;
   assign dif = x - tos_ff;
   assign rem_sh = {rem_ff[63:0], num_ff[127]};
   assign prod_a = step_ff[1] ? ua_ff[63:32] : ua_ff[31:0];
   assign prod_b = step_ff[0] ? ub_ff[63:32] : ub_ff[31:0];

   always_comb begin
      case (sh_ff)
         2'd0:    prod_sh = {64'd0, prod_ff};
         2'd1:    prod_sh = {32'd0, prod_ff, 32'd0};
         default: prod_sh = {prod_ff, 64'd0};
      endcase
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      err_in   = err_ff;
      tos_in   = tos_ff;
      op_in    = op_ff;
      neg_in   = neg_ff;
      ua_in    = ua_ff;
      ub_in    = ub_ff;
      prod_in  = prod_ff;
      sh_in    = sh_ff;
      acc_in   = acc_ff;
      step_in  = step_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      rsp_in   = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd_pop  = 1'b0;
      wr_en    = 1'b0;
      rd_en    = 1'b0;

      unique case (state_ff)
         B_IDLE: begin
            if (!cmd_empty && (cmd_head.kind != rpn_pkg::CMD_END || out_free)) begin
               cmd_pop = 1'b1;
               if (cmd_head.kind == rpn_pkg::CMD_END) begin
                  // result beat, then start over
                  rsp_valid_in = 1'b1;
                  rsp_in.value = '0;
                  rsp_in.status = err_ff;
                  if (err_ff == rpn_pkg::ST_OK) begin
                     if (count_ff != CW'(1)) rsp_in.status = rpn_pkg::ST_INVALID;
                     else rsp_in.value = tos_ff;
                  end
                  count_in = '0;
                  err_in   = rpn_pkg::ST_OK;
               end else if (err_ff == rpn_pkg::ST_OK) begin
                  unique case (cmd_head.kind)
                     rpn_pkg::CMD_ERR: err_in = cmd_head.code;
                     rpn_pkg::CMD_PUSH: begin
                        if (count_ff == CW'(STACK_DEPTH)) begin
                           err_in = rpn_pkg::ST_OVERFLOW;
                        end else begin
                           wr_en    = (count_ff != '0);
                           tos_in   = cmd_head.data;
                           count_in = count_ff + CW'(1);
                        end
                     end
                     rpn_pkg::CMD_NEG: begin
                        if (count_ff == '0) err_in = rpn_pkg::ST_FEW_OPS;
                        else tos_in = (tos_ff == rpn_pkg::VAL_MIN) ? rpn_pkg::VAL_MAX
                                                                   : 64'd0 - tos_ff;
                     end
                     default: begin
                        if (count_ff < CW'(2)) begin
                           err_in = rpn_pkg::ST_FEW_OPS;
                        end else begin
                           rd_en    = 1'b1;
                           op_in    = cmd_head.kind;
                           state_in = B_READ;
                        end
                     end
                  endcase
               end
            end
         end
         B_READ: begin
            // second operand arrives from the ram
            count_in = cnt_m1;
            neg_in   = x[63] ^ tos_ff[63];
            ua_in    = rpn_pkg::mag_of(x);
            ub_in    = rpn_pkg::mag_of(tos_ff);
            step_in  = '0;
            acc_in   = '0;
            state_in = B_IDLE;
            case (op_ff)
               rpn_pkg::CMD_ADD: begin
                  tos_in = (!(x[63] ^ tos_ff[63]) && (sum[63] ^ x[63]))
                           ? (x[63] ? rpn_pkg::VAL_MIN : rpn_pkg::VAL_MAX) : sum;
               end
               rpn_pkg::CMD_SUB: begin
                  tos_in = ((x[63] ^ tos_ff[63]) && (dif[63] ^ x[63]))
                           ? (x[63] ? rpn_pkg::VAL_MIN : rpn_pkg::VAL_MAX) : dif;
               end
               rpn_pkg::CMD_MUL: state_in = B_MUL;
               default: begin
                  if (tos_ff == 64'd0) begin
                     err_in = rpn_pkg::ST_DIV_ZERO;
                  end else begin
                     num_in   = {64'd0, rpn_pkg::mag_of(x)} << FRACTION_BITS;
                     rem_in   = '0;
                     acc_in   = '0;
                     state_in = B_DIV;
                  end
               end
            endcase
         end
         B_MUL: begin
            // four 32x32 partial products, each registered before it is accumulated
            if (step_ff != 8'd0) acc_in = acc_ff + prod_sh;
            if (step_ff < 8'd4) begin
               prod_in = prod_a * prod_b;
               sh_in   = 2'(step_ff[1] + step_ff[0]);
            end
            step_in = step_ff + 8'd1;
            if (step_ff == 8'd4) state_in = B_DONE;
         end
         B_DIV: begin
            // restoring divide, one quotient bit a cycle into acc
            if (rem_sh >= {1'b0, ub_ff}) begin
               rem_in = rem_sh - {1'b0, ub_ff};
               acc_in = {acc_ff[126:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               acc_in = {acc_ff[126:0], 1'b0};
            end
            num_in  = {num_ff[126:0], 1'b0};
            step_in = step_ff + 8'd1;
            if (step_ff == 8'd127) state_in = B_DONE;
         end
         B_DONE: begin
            if (op_ff == rpn_pkg::CMD_MUL) begin
               tos_in = rpn_pkg::sat_mag(neg_ff, |acc_ff[127:64+FRACTION_BITS],
                                         acc_ff[63+FRACTION_BITS:FRACTION_BITS]);
            end else begin
               tos_in = rpn_pkg::sat_mag(neg_ff, |acc_ff[127:64], acc_ff[63:0]);
            end
            state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         count_ff     <= '0;
         err_ff       <= rpn_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff  <= tos_in;
      op_ff   <= op_in;
      neg_ff  <= neg_in;
      ua_ff   <= ua_in;
      ub_ff   <= ub_in;
      prod_ff <= prod_in;
      sh_ff   <= sh_in;
      acc_ff  <= acc_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      rsp_ff  <= rsp_in;
   end

endmodule

`default_nettype wire

>>> rtl/rpn_checker.sv
// ----------------------------------------------------------------------------
// rpn_checker
// port level checks for the rpn evaluator
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rpn_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire rpn_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire rpn_pkg::rsp_type rsp_data
);

   // failed evaluation reports a zero value
   `RPN_ASSERT(a_zero_on_error, rsp_valid && rsp_data.status != rpn_pkg::ST_OK |-> rsp_data.value == 64'd0, "value not zero on error")

   // status stays within the defined codes
   `RPN_ASSERT(a_status_range, rsp_valid |-> rsp_data.status <= rpn_pkg::ST_OVERFLOW, "status code out of range")

   // a stalled result beat holds
   `RPN_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled result changed")

   // a stalled input beat holds
   `RPN_ASSERT(a_req_hold, req_valid && req_stall |=> req_valid && $stable(req_data), "stalled request changed")

   // no result beat right after reset
   `RPN_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "result beat after reset")

endmodule

bind rpn_stack_evaluator rpn_checker u_rpn_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

`default_nettype wire
